// ===== rtl/fra_pkg.sv =====
// Shared types, sizes and helpers for the frame ring allocator.
// No dependencies; imported by frame_ring_allocator and its testbench.
`default_nettype none

package fra_pkg;

  // Pool geometry; ALIGN_BYTES must be a power of two
  localparam int POOL_BYTES  = 1048576;
  localparam int ALIGN_BYTES = 256;
  localparam int FRAMES      = 3;

  localparam int ALIGN_LOG2  = $clog2(ALIGN_BYTES);
  localparam int OFF_W       = 21;   // offsets, sizes and byte counts
  localparam int SUM_W       = OFF_W + 1;
  localparam int SLOT_IN_W   = 3;
  localparam int SLOT_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int ADDR_W      = 64;
  localparam int STATUS_W    = 3;

  localparam int IN_DATA_W   = 24;   // alloc_size, frame_slot
  localparam int OUT_DATA_W  = 88;   // address, status, bytes_in_use

  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [SLOT_W-1:0] slot_t;

  localparam sum_t POOL_SUM = SUM_W'(POOL_BYTES);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FRAME = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_ZERO       = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_TOO_LARGE  = 3'd3,
    ST_FULL       = 3'd4,
    ST_NO_ROOM    = 3'd5
  } status_t;

  // Fold a raw slot number below FRAMES by repeated subtraction (3-bit value)
  function automatic slot_t slot_wrap(input logic [SLOT_IN_W-1:0] raw);
    logic [SLOT_IN_W-1:0] v;
    v = raw;
    for (int i = 0; i < (1 << SLOT_IN_W); i++) begin
      if (v >= SLOT_IN_W'(FRAMES)) begin
        v = v - SLOT_IN_W'(FRAMES);
      end
    end
    return SLOT_W'(v);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/frame_ring_allocator.sv =====
// Frame ring allocator: ring allocation over a byte pool with per-frame reclaim.
// Each request passes through the input register and then the result register.
// Throughput: one request per cycle; the single pass of compares and adds between
// the two registers sets that rate, and backpressure stalls both stages.
// Reset (rst, synchronous): head, tail, usage, slot counts, current slot and
// base_address clear to zero; both pipeline stages empty.
// Depends on fra_pkg.
`default_nettype none

module frame_ring_allocator
  import fra_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration: base_address
  input  wire logic                  cfg_we,
  input  wire logic [ADDR_W-1:0]     cfg_wdata,
  // request stream
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [20:0] alloc_size, [23:21] frame_slot
  input  wire logic                  s_axis_tuser,  // [0] operation
  // result stream
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output      logic [OUT_DATA_W-1:0] m_axis_tdata   // [63:0] address, [66:64] status,
                                                    // [87:67] bytes_in_use
);

  // Allocator state
  logic [ADDR_W-1:0] base_address;
  off_t              head_offset;
  off_t              tail_offset;
  off_t              used_total;
  off_t              slot_used [FRAMES];
  slot_t             current_slot;

  // Input stage
  logic                 in_valid;
  op_t                  in_op;
  off_t                 in_size;
  logic [SLOT_IN_W-1:0] in_slot;

  // Result stage
  logic                 out_valid;
  logic [ADDR_W-1:0]    out_address;
  status_t              out_status;
  off_t                 out_in_use;

  logic advance;

  // Next state and result
  off_t              head_next;
  off_t              tail_next;
  off_t              used_next;
  slot_t             slot_next;
  off_t              charge_next;      // new count for the charged slot
  logic              slot_clear;
  logic              slot_write;
  logic [ADDR_W-1:0] address_next;
  status_t           status_next;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Process the registered request against the current state
  always_comb begin
    sum_t  size_w;
    sum_t  used_w;
    sum_t  head0;
    sum_t  tail0;
    sum_t  to_end;
    sum_t  head1;
    sum_t  used1;
    sum_t  charged;
    sum_t  avail;
    sum_t  tail_sum;
    off_t  freed;
    slot_t fslot;
    logic  wrap;

    size_w   = SUM_W'(in_size);
    used_w   = SUM_W'(used_total);
    head0    = '0;
    tail0    = '0;
    to_end   = '0;
    head1    = '0;
    used1    = '0;
    charged  = '0;
    avail    = '0;
    tail_sum = '0;
    freed    = '0;
    fslot    = '0;
    wrap     = 1'b0;

    head_next    = head_offset;
    tail_next    = tail_offset;
    used_next    = used_total;
    slot_next    = current_slot;
    charge_next  = slot_used[current_slot];
    slot_clear   = 1'b0;
    slot_write   = 1'b0;
    address_next = '0;
    status_next  = ST_OK;

    if (in_op == OP_ALLOC) begin
      // Checks in priority order
      if (in_size == '0) begin
        status_next = ST_ZERO;
      end else if ((in_size[((ALIGN_LOG2 > 0) ? (ALIGN_LOG2 - 1) : 0):0] != '0) &&
                   (ALIGN_LOG2 > 0)) begin
        status_next = ST_MISALIGNED;
      end else if (size_w > POOL_SUM) begin
        status_next = ST_TOO_LARGE;
      end else if (used_w + size_w > POOL_SUM) begin
        status_next = ST_FULL;
      end else begin
        // Empty pool restarts at offset zero
        head0 = (used_total == '0) ? '0 : SUM_W'(head_offset);
        tail0 = (used_total == '0) ? '0 : SUM_W'(tail_offset);
        wrap  = tail0 < head0;
        to_end = POOL_SUM - head0;
        if (wrap && to_end >= size_w) begin
          // Fits before the end of the pool
          head1   = head0;
          used1   = used_w;
          charged = '0;
          avail   = to_end;
        end else if (wrap) begin
          // Charge the skipped end bytes and wrap head
          head1   = '0;
          used1   = used_w + to_end;
          charged = to_end;
          avail   = tail0;
        end else begin
          head1   = head0;
          used1   = used_w;
          charged = '0;
          avail   = (used_w == '0) ? POOL_SUM : tail0 - head0;
        end

        head_next  = OFF_W'(head1);
        tail_next  = OFF_W'(tail0);
        used_next  = OFF_W'(used1);
        slot_write = 1'b1;
        if (avail >= size_w) begin
          address_next = base_address + ADDR_W'(head1);
          head_next    = OFF_W'(head1 + size_w);
          used_next    = OFF_W'(used1 + size_w);
          charge_next  = OFF_W'(SUM_W'(slot_used[current_slot]) + charged + size_w);
        end else begin
          status_next  = ST_NO_ROOM;
          charge_next  = OFF_W'(SUM_W'(slot_used[current_slot]) + charged);
        end
      end
    end else begin
      // Begin frame: make the slot current and reclaim its bytes
      fslot     = slot_wrap(in_slot);
      slot_next = fslot;
      freed     = slot_used[fslot];
      if (freed != '0) begin
        tail_sum   = SUM_W'(tail_offset) + SUM_W'(freed);
        tail_next  = (tail_sum >= POOL_SUM) ? OFF_W'(tail_sum - POOL_SUM) : OFF_W'(tail_sum);
        used_next  = (used_total >= freed) ? used_total - freed : '0;
        slot_clear = 1'b1;
      end
      if (used_next == '0) begin
        head_next = '0;
        tail_next = '0;
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
    end else if (cfg_we) begin
      base_address <= cfg_wdata;
    end
  end

  // Capture requests into the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= op_t'(s_axis_tuser);
      in_size <= s_axis_tdata[OFF_W-1:0];
      in_slot <= s_axis_tdata[OFF_W +: SLOT_IN_W];
    end
  end

  // Commit state on each processed request
  always_ff @(posedge clk) begin
    if (rst) begin
      head_offset  <= '0;
      tail_offset  <= '0;
      used_total   <= '0;
      current_slot <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        slot_used[i] <= '0;
      end
    end else if (advance) begin
      head_offset  <= head_next;
      tail_offset  <= tail_next;
      used_total   <= used_next;
      current_slot <= slot_next;
      if (slot_clear) begin
        slot_used[slot_next] <= '0;
      end else if (slot_write) begin
        slot_used[current_slot] <= charge_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_address <= address_next;
      out_status  <= status_next;
      out_in_use  <= used_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_in_use, out_status, out_address};

  // An empty pool always sits at offset zero
  assert property (@(posedge clk) disable iff (rst)
    (used_total == '0) |-> (head_offset == '0 && tail_offset == '0))
    else $error("empty pool with nonzero head or tail");

  // Usage never exceeds the pool
  assert property (@(posedge clk) disable iff (rst)
    SUM_W'(used_total) <= POOL_SUM)
    else $error("bytes in use beyond pool size");

  // Failed requests return a null address
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |-> (out_address == '0))
    else $error("nonzero address on failed request");

  // A granted allocation leaves bytes in use
  assert property (@(posedge clk) disable iff (rst)
    (advance && in_op == OP_ALLOC && status_next == ST_OK) |=> (used_total != '0))
    else $error("allocation granted with empty pool");

endmodule

`default_nettype wire

// ===== tb/frame_ring_allocator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for frame_ring_allocator: directed table, then random traffic
// with random source/sink bursts, compared against an in-bench ring allocator model.
// Depends on fra_pkg and rtl/frame_ring_allocator.sv.

module frame_ring_allocator_tb;
  import fra_pkg::*;

  // One stimulus row; typed rows carry a hand-written expected result
  typedef struct packed {
    op_t         op;
    logic [20:0] size;
    logic [2:0]  slot;
    logic        typed;
    logic [63:0] addr;
    status_t     status;
    logic [20:0] in_use;
  } stim_row_t;

  typedef struct packed {
    logic [63:0] addr;
    status_t     status;
    logic [20:0] in_use;
  } alloc_result_t;

  localparam int DIRECTED_COUNT = 25;

  // Directed table; addresses assume base_address at its reset value of 0
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{OP_ALLOC, 21'h000000, 3'd0, 1'b1, 64'd0,     ST_ZERO,       21'h000000},
    '{OP_ALLOC, 21'h000001, 3'd0, 1'b1, 64'd0,     ST_MISALIGNED, 21'h000000},
    '{OP_ALLOC, 21'h0000FF, 3'd0, 1'b1, 64'd0,     ST_MISALIGNED, 21'h000000},
    '{OP_ALLOC, 21'h1FFFFF, 3'd7, 1'b1, 64'd0,     ST_MISALIGNED, 21'h000000},
    '{OP_ALLOC, 21'h1FFF00, 3'd0, 1'b1, 64'd0,     ST_TOO_LARGE,  21'h000000},
    '{OP_ALLOC, 21'h100100, 3'd0, 1'b1, 64'd0,     ST_TOO_LARGE,  21'h000000},
    '{OP_ALLOC, 21'h000100, 3'd0, 1'b1, 64'd0,     ST_OK,         21'h000100},
    '{OP_ALLOC, 21'h100000, 3'd0, 1'b1, 64'd0,     ST_FULL,       21'h000100},
    '{OP_ALLOC, 21'h0FFF00, 3'd0, 1'b1, 64'h100,   ST_OK,         21'h100000},
    '{OP_ALLOC, 21'h000100, 3'd0, 1'b1, 64'd0,     ST_FULL,       21'h100000},
    '{OP_FRAME, 21'h000000, 3'd1, 1'b1, 64'd0,     ST_OK,         21'h100000},
    '{OP_FRAME, 21'h000000, 3'd0, 1'b1, 64'd0,     ST_OK,         21'h000000},
    // slot numbers of FRAMES and above fold back, size ignored on a frame request
    '{OP_FRAME, 21'h1FFFFF, 3'd4, 1'b0, 64'd0,     ST_OK,         21'h000000},
    '{OP_ALLOC, 21'h080000, 3'd0, 1'b0, 64'd0,     ST_OK,         21'h000000},
    '{OP_FRAME, 21'h000000, 3'd5, 1'b0, 64'd0,     ST_OK,         21'h000000},
    '{OP_ALLOC, 21'h060000, 3'd0, 1'b0, 64'd0,     ST_OK,         21'h000000},
    '{OP_FRAME, 21'h000000, 3'd7, 1'b0, 64'd0,     ST_OK,         21'h000000},
    // wrap at the pool end, then fail for lack of contiguous room
    '{OP_ALLOC, 21'h090000, 3'd0, 1'b0, 64'd0,     ST_OK,         21'h000000},
    '{OP_FRAME, 21'h000000, 3'd6, 1'b0, 64'd0,     ST_OK,         21'h000000},
    '{OP_ALLOC, 21'h040000, 3'd0, 1'b0, 64'd0,     ST_OK,         21'h000000},
    '{OP_FRAME, 21'h000000, 3'd2, 1'b0, 64'd0,     ST_OK,         21'h000000},
    // tail wraps through the pool end, then the pool drains to empty
    '{OP_FRAME, 21'h000000, 3'd1, 1'b0, 64'd0,     ST_OK,         21'h000000},
    '{OP_FRAME, 21'h000000, 3'd3, 1'b0, 64'd0,     ST_OK,         21'h000000},
    '{OP_ALLOC, 21'h100000, 3'd7, 1'b0, 64'd0,     ST_OK,         21'h000000},
    '{OP_FRAME, 21'h000000, 3'd0, 1'b0, 64'd0,     ST_OK,         21'h000000}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [ADDR_W-1:0]     cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [20:0] alloc_size, [23:21] frame_slot
  logic                  s_axis_tuser = 1'b0; // [0] operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // [63:0] address, [66:64] status,
                                              // [87:67] bytes_in_use

  // Allocator model state
  logic [63:0]  ring_base = '0;
  int unsigned  ring_head = 0;
  int unsigned  ring_tail = 0;
  int unsigned  ring_used = 0;
  int unsigned  frame_bytes [FRAMES] = '{default: 0};
  int unsigned  frame_cur = 0;

  alloc_result_t outstanding_allocs [$];
  stim_row_t     held_row = '0;
  int            mismatch_count = 0;
  logic          idle_allowed = 1'b1;
  logic          src_bursts_on = 1'b1;
  logic          sink_bursts_on = 1'b1;
  int            sink_stall_left = 0;

  frame_ring_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk = ~clk;

  // Charge bytes to the current frame slot
  function automatic void charge_frame(int unsigned bytes);
    frame_bytes[frame_cur] += bytes;
    ring_used += bytes;
  endfunction

  // Advance the allocator model by one request and return its result
  function automatic alloc_result_t allocate_or_reclaim(op_t op, logic [20:0] size,
                                                        logic [2:0] slot_raw);
    alloc_result_t r;
    int unsigned   sz;
    int unsigned   to_end;
    int unsigned   avail;
    int unsigned   freed;
    bit            placed;
    r.addr   = '0;
    r.status = ST_OK;
    sz       = 32'(size);
    placed   = 1'b0;
    if (op == OP_FRAME) begin
      // reclaim everything charged to the slot becoming current
      frame_cur = slot_raw % FRAMES;
      freed = frame_bytes[frame_cur];
      if (freed > 0) begin
        ring_tail = (ring_tail + freed) % POOL_BYTES;
        ring_used = (ring_used >= freed) ? ring_used - freed : 0;
        frame_bytes[frame_cur] = 0;
      end
      if (ring_used == 0) begin
        ring_head = 0;
        ring_tail = 0;
      end
    end else if (sz == 0) begin
      r.status = ST_ZERO;
    end else if (sz % ALIGN_BYTES != 0) begin
      r.status = ST_MISALIGNED;
    end else if (sz > POOL_BYTES) begin
      r.status = ST_TOO_LARGE;
    end else if (ring_used + sz > POOL_BYTES) begin
      r.status = ST_FULL;
    end else begin
      if (ring_used == 0) begin
        ring_head = 0;
        ring_tail = 0;
      end
      // place before the pool end, or skip the end bytes and wrap head
      if (ring_tail < ring_head) begin
        to_end = POOL_BYTES - ring_head;
        if (to_end >= sz) begin
          placed = 1'b1;
        end else begin
          charge_frame(to_end);
          ring_head = 0;
        end
      end
      if (!placed) begin
        avail = (ring_used == 0) ? POOL_BYTES : ring_tail - ring_head;
        if (avail >= sz) placed = 1'b1;
        else r.status = ST_NO_ROOM;
      end
      if (placed) begin
        r.addr = ring_base + 64'(ring_head);
        charge_frame(sz);
        ring_head += sz;
      end
    end
    r.in_use = ring_used[20:0];
    return r;
  endfunction

  // Random request: mostly aligned sizes and frame changes, some malformed sizes
  function automatic stim_row_t random_row();
    stim_row_t row;
    int        pick;
    row      = '0;
    row.slot = 3'($urandom_range(0, 7));
    row.size = 21'($urandom);
    row.op   = OP_ALLOC;
    pick     = $urandom_range(0, 99);
    if (pick < 18) row.op = OP_FRAME;
    else if (pick < 20) row.size = '0;
    else if (pick < 24) row.size = 21'($urandom);
    else if (pick < 26) row.size = 21'($urandom_range(4097, 8191) << 8);
    else if (pick < 28) row.size = 21'(POOL_BYTES);
    else if (pick < 34) row.size = 21'($urandom_range(1, 4096) << 8);
    else row.size = 21'($urandom_range(1, 384) << 8);
    return row;
  endfunction

  // Present one request and hold it until accepted
  task automatic issue_request(stim_row_t row);
    int gap;
    if (idle_allowed && src_bursts_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row.slot, row.size};
    s_axis_tuser  <= row.op;
    held_row      <= row;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drain all results, let the pipeline empty, then load a new base address
  task automatic write_base_when_idle(logic [63:0] value);
    s_axis_tvalid <= 1'b0;
    // let the last accepted request reach the expected queue
    @(posedge clk);
    while (outstanding_allocs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ring_base = value;
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0) src_bursts_on = !src_bursts_on;
      issue_request(random_row());
    end
  endtask

  // Sink side: random stall bursts on the result stream
  always @(posedge clk) begin
    if (sink_stall_left != 0) begin
      sink_stall_left <= sink_stall_left - 1;
      m_axis_tready   <= (sink_stall_left == 1);
    end else if (idle_allowed && sink_bursts_on && $urandom_range(0, 9) == 0) begin
      sink_stall_left <= $urandom_range(1, 12);
      m_axis_tready   <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
    if ($urandom_range(0, 299) == 0) sink_bursts_on <= !sink_bursts_on;
  end

  // Compare results first, then predict the request accepted on this edge
  always @(posedge clk) begin
    alloc_result_t want;
    alloc_result_t got;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.addr   = m_axis_tdata[63:0];
        got.status = status_t'(m_axis_tdata[66:64]);
        got.in_use = m_axis_tdata[87:67];
        if (outstanding_allocs.size() == 0) begin
          $error("result with nothing outstanding: address %h status %0d bytes_in_use %0d",
                 got.addr, got.status, got.in_use);
          mismatch_count++;
        end else begin
          want = outstanding_allocs.pop_front();
          if (got.addr !== want.addr) begin
            $error("address expected %h actual %h", want.addr, got.addr);
            mismatch_count++;
          end
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            mismatch_count++;
          end
          if (got.in_use !== want.in_use) begin
            $error("bytes_in_use expected %0d actual %0d", want.in_use, got.in_use);
            mismatch_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = allocate_or_reclaim(op_t'(s_axis_tuser), s_axis_tdata[20:0],
                                   s_axis_tdata[23:21]);
        if (held_row.typed) begin
          want.addr   = held_row.addr;
          want.status = held_row.status;
          want.in_use = held_row.in_use;
        end
        outstanding_allocs.push_back(want);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table at the reset base address
    for (int i = 0; i < DIRECTED_COUNT; i++) issue_request(DIRECTED_ROWS[i]);

    // Random traffic across several base addresses, extremes included
    write_base_when_idle(64'hFFFF_FFFF_FFFF_FFFF);
    run_random(500);
    write_base_when_idle({$urandom, $urandom});
    run_random(500);
    write_base_when_idle(64'd0);
    run_random(250);
    idle_allowed <= 1'b0;
    run_random(300);

    // Drain and let the pipeline settle
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding_allocs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fra_pkg.sv
rtl/frame_ring_allocator.sv
tb/frame_ring_allocator_tb.sv
